// File: design/prd_pkg.sv
// Shared widths, register codes and reset values for the pairwise repulsion force block.
`timescale 1ns / 1ps
package prd_pkg;

	localparam int COORD_BITS_DEF = 16;

	localparam int DIST_W = 15;  // cutoff and per-axis distance
	localparam int FS_W   = 16;  // force scale
	localparam int CS_W   = 16;  // charge strength
	localparam int CAP_W  = 15;  // force cap
	localparam int SQ_W   = 2 * DIST_W;
	localparam int R2_W   = SQ_W + 1;
	localparam int ROOT_W = 16;
	localparam int COEF_W = 15;
	localparam int NUM_W  = CS_W + 16;
	localparam int PROD_W = COEF_W + DIST_W;
	localparam int CM_W   = CS_W + R2_W;
	localparam int G_W    = COEF_W + FS_W - 8;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FORCE_SCALE     = 3'd0,
		CFG_CUTOFF_DISTANCE = 3'd1,
		CFG_CHARGE_STRENGTH = 3'd2,
		CFG_FORCE_CAP       = 3'd3
	} cfg_reg_t;

	localparam logic [FS_W-1:0]   FS_RESET  = 16'd256;
	localparam logic [DIST_W-1:0] CUT_RESET = 15'd2560;
	localparam logic [CS_W-1:0]   CS_RESET  = 16'd256;
	localparam logic [CAP_W-1:0]  CAP_RESET = 15'd256;

endpackage

// File: design/prd_dly.sv
// Enabled delay line with cleared reset, used to carry sideband data along the pipeline.
`timescale 1ns / 1ps
module prd_dly #(
	parameter int W = 8,
	parameter int D = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         en,
	input  logic [W-1:0] din,
	output logic [W-1:0] dout
);

	logic [W-1:0] sr_q [D];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < D; i++) sr_q[i] <= '0;
		end else if (en) begin
			sr_q[0] <= din;
			for (int i = 1; i < D; i++) sr_q[i] <= sr_q[i-1];
		end
	end

	assign dout = sr_q[D-1];

endmodule

// File: design/prd_div.sv
// Pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps
module prd_div #(
	parameter int NW = 32,
	parameter int DW = 31,
	parameter int QW = 15
) (
	input  logic          clk,
	input  logic          en,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic [QW-1:0] quo
);

	logic [DW-1:0] rem_s [QW];
	logic [DW-1:0] den_s [QW];
	logic [QW-1:0] lo_s  [QW];
	logic [QW-1:0] q_s   [QW];

	for (genvar k = 0; k < QW; k++) begin : g_stage
		logic [DW-1:0] rem_in, den_in;
		logic [QW-1:0] lo_in, q_in;
		logic [DW:0]   trial, diff;
		logic          ge;

		if (k == 0) begin : g_first
			assign rem_in = DW'(num >> QW);
			assign den_in = den;
			assign lo_in  = num[QW-1:0];
			assign q_in   = '0;
		end else begin : g_next
			assign rem_in = rem_s[k-1];
			assign den_in = den_s[k-1];
			assign lo_in  = lo_s[k-1];
			assign q_in   = q_s[k-1];
		end

		assign trial = {rem_in, lo_in[QW-1]};
		assign ge    = trial >= {1'b0, den_in};
		assign diff  = trial - {1'b0, den_in};

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= ge ? diff[DW-1:0] : trial[DW-1:0];
				den_s[k] <= den_in;
				lo_s[k]  <= {lo_in[QW-2:0], 1'b0};
				q_s[k]   <= {q_in[QW-2:0], ge};
			end
		end
	end

	assign quo = q_s[QW-1];

endmodule

// File: design/prd_sqrt.sv
// Pipelined integer square root, one root bit per stage.
`timescale 1ns / 1ps
module prd_sqrt #(
	parameter int RW = 16
) (
	input  logic            clk,
	input  logic            en,
	input  logic [2*RW-1:0] rad,
	output logic [RW-1:0]   root
);

	localparam int MW = RW + 2;

	logic [MW-1:0]   rem_s  [RW];
	logic [RW-1:0]   root_s [RW];
	logic [2*RW-1:0] lo_s   [RW];

	for (genvar k = 0; k < RW; k++) begin : g_stage
		logic [MW-1:0]   rem_in;
		logic [RW-1:0]   root_in;
		logic [2*RW-1:0] lo_in;
		logic [MW+1:0]   cat, trial, diff;
		logic            ge;

		if (k == 0) begin : g_first
			assign rem_in  = '0;
			assign root_in = '0;
			assign lo_in   = rad;
		end else begin : g_next
			assign rem_in  = rem_s[k-1];
			assign root_in = root_s[k-1];
			assign lo_in   = lo_s[k-1];
		end

		assign cat   = {rem_in, lo_in[2*RW-1:2*RW-2]};
		assign trial = {2'b00, root_in, 2'b01};
		assign ge    = cat >= trial;
		assign diff  = cat - trial;

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= ge ? diff[MW-1:0] : cat[MW-1:0];
				root_s[k] <= {root_in[RW-2:0], ge};
				lo_s[k]   <= {lo_in[2*RW-3:0], 2'b00};
			end
		end
	end

	assign root = root_s[RW-1];

endmodule

// File: design/pairwise_repulsion_force.sv
// Top level of the pairwise inverse-square repulsion force pipeline.
`timescale 1ns / 1ps
// Pairwise repulsion force: one particle pair in, one updated velocity out.
// Slave channel s_*: tdata carries self_x, self_y, self_vx, self_vy, other_x,
// other_y (COORD_BITS each, lowest first); tuser carries self_marked (bit 0)
// and other_marked (bit 1). Master channel m_*: tdata carries new_vx, new_vy;
// tuser bit 0 is force_applied.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; index 0
// force_scale, 1 cutoff_distance, 2 charge_strength, 3 force_cap. Higher
// indexes are dropped. cfg_ready is always high; write only while idle.
// Throughput: one pair per cycle while the receiver does not stall. The
// pipeline depth comes from the 16-stage square root and the two 15-stage
// divider chains (charge over r^2, and force times d over r).
// Reset clears all valid bits and loads the register defaults; no clearing
// pass is needed. When the receiver stalls, the whole pipeline holds in
// place and s_tready drops, so nothing is lost or repeated; a waiting result
// holds the input off even while the pipeline still has bubbles.
module pairwise_repulsion_force #(
	parameter int COORD_BITS = prd_pkg::COORD_BITS_DEF,
	localparam int IN_W  = ((6 * COORD_BITS + 7) / 8) * 8,
	localparam int OUT_W = ((2 * COORD_BITS + 7) / 8) * 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// self_x, self_y, self_vx, self_vy, other_x, other_y, zero pad
	input  logic [IN_W-1:0]                 s_tdata,
	// self_marked, other_marked
	input  logic [1:0]                      s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// new_vx, new_vy, zero pad
	output logic [OUT_W-1:0]                m_tdata,
	// force_applied
	output logic [0:0]                      m_tuser,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [prd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [prd_pkg::CFG_DATA_W-1:0]  cfg_data
);

	localparam int C      = COORD_BITS;
	localparam int DIST_W = prd_pkg::DIST_W;
	localparam int AW     = (C + 1 > DIST_W) ? C + 1 : DIST_W;
	localparam int G_W    = prd_pkg::G_W;
	localparam int SUM_W  = ((C > G_W + 1) ? C : G_W + 1) + 1;
	localparam int SB_W   = 4 + 2 * C;

	// Configuration registers.
	logic [prd_pkg::FS_W-1:0]  fs_q;
	logic [DIST_W-1:0]         cut_q;
	logic [prd_pkg::CS_W-1:0]  cs_q;
	logic [prd_pkg::CAP_W-1:0] cap_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fs_q  <= prd_pkg::FS_RESET;
			cut_q <= prd_pkg::CUT_RESET;
			cs_q  <= prd_pkg::CS_RESET;
			cap_q <= prd_pkg::CAP_RESET;
		end else if (cfg_valid) begin
			case (prd_pkg::cfg_reg_t'(cfg_index))
				prd_pkg::CFG_FORCE_SCALE:     fs_q  <= cfg_data;
				prd_pkg::CFG_CUTOFF_DISTANCE: cut_q <= cfg_data[DIST_W-1:0];
				prd_pkg::CFG_CHARGE_STRENGTH: cs_q  <= cfg_data;
				prd_pkg::CFG_FORCE_CAP:       cap_q <= cfg_data[prd_pkg::CAP_W-1:0];
				default: ;
			endcase
		end
	end

	// One enable for every stage: advance when the output slot is free or taken.
	logic en;
	logic out_valid_q;
	assign en       = !out_valid_q || m_tready;
	assign s_tready = en;

	// Stage 1: separation, magnitudes and per-axis cutoff test.
	logic [C-1:0] sx, sy, vx, vy, ox, oy;
	logic [C:0]   dx, dy, adx_f, ady_f;
	logic         marked;

	assign sx = s_tdata[0*C +: C];
	assign sy = s_tdata[1*C +: C];
	assign vx = s_tdata[2*C +: C];
	assign vy = s_tdata[3*C +: C];
	assign ox = s_tdata[4*C +: C];
	assign oy = s_tdata[5*C +: C];
	assign marked = s_tuser[0] | s_tuser[1];

	assign dx    = {sx[C-1], sx} - {ox[C-1], ox};
	assign dy    = {sy[C-1], sy} - {oy[C-1], oy};
	assign adx_f = dx[C] ? (C + 1)'(0) - dx : dx;
	assign ady_f = dy[C] ? (C + 1)'(0) - dy : dy;

	logic              v_s1, ok_s1, nx_s1, ny_s1;
	logic [C-1:0]      vx_s1, vy_s1;
	logic [DIST_W-1:0] adx_s1, ady_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ok_s1  <= !marked && (AW'(adx_f) <= AW'(cut_q)) && (AW'(ady_f) <= AW'(cut_q));
			nx_s1  <= dx[C];
			ny_s1  <= dy[C];
			vx_s1  <= vx;
			vy_s1  <= vy;
			adx_s1 <= DIST_W'(adx_f);
			ady_s1 <= DIST_W'(ady_f);
		end
	end

	// Stage 2: squares.
	logic                       v_s2, ok_s2, nx_s2, ny_s2;
	logic [C-1:0]               vx_s2, vy_s2;
	logic [DIST_W-1:0]          adx_s2, ady_s2;
	logic [prd_pkg::SQ_W-1:0]   sqx_s2, sqy_s2, cut2_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ok_s2   <= ok_s1;
			nx_s2   <= nx_s1;
			ny_s2   <= ny_s1;
			vx_s2   <= vx_s1;
			vy_s2   <= vy_s1;
			adx_s2  <= adx_s1;
			ady_s2  <= ady_s1;
			sqx_s2  <= adx_s1 * adx_s1;
			sqy_s2  <= ady_s1 * ady_s1;
			cut2_s2 <= cut_q * cut_q;
		end
	end

	// Stage 3: r^2 and the radial cutoff; coincident points get no force.
	logic                     v_s3, ok_s3, nx_s3, ny_s3;
	logic [C-1:0]             vx_s3, vy_s3;
	logic [DIST_W-1:0]        adx_s3, ady_s3;
	logic [prd_pkg::R2_W-1:0] r2_c, r2_s3;

	assign r2_c = prd_pkg::R2_W'(sqx_s2) + prd_pkg::R2_W'(sqy_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ok_s3  <= ok_s2 && (r2_c != '0) && (r2_c <= {1'b0, cut2_s2});
			nx_s3  <= nx_s2;
			ny_s3  <= ny_s2;
			vx_s3  <= vx_s2;
			vy_s3  <= vy_s2;
			adx_s3 <= adx_s2;
			ady_s3 <= ady_s2;
			r2_s3  <= r2_c;
		end
	end

	// Sideband to stage 37.
	logic [SB_W-1:0] sb_s37;
	logic            v_s37, ok_s37, nx_s37, ny_s37;
	logic [C-1:0]    vx_s37, vy_s37;

	prd_dly #(.W(SB_W), .D(34)) u_sb_dly (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.din    ({v_s3, ok_s3, nx_s3, ny_s3, vx_s3, vy_s3}),
		.dout   (sb_s37)
	);

	assign {v_s37, ok_s37, nx_s37, ny_s37, vx_s37, vy_s37} = sb_s37;

	// Magnitudes to stage 19.
	logic [DIST_W-1:0] adx_s19, ady_s19;

	prd_dly #(.W(2 * DIST_W), .D(16)) u_ad_dly (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.din    ({adx_s3, ady_s3}),
		.dout   ({adx_s19, ady_s19})
	);

	// Charge over r^2: 15-bit quotient ready at stage 18, hold one more.
	logic [prd_pkg::COEF_W-1:0] q_s18, q_s19;

	prd_div #(.NW(prd_pkg::NUM_W), .DW(prd_pkg::R2_W), .QW(prd_pkg::COEF_W)) u_coef_div (
		.clk (clk),
		.en  (en),
		.num ({cs_q, 16'd0}),
		.den (r2_s3),
		.quo (q_s18)
	);

	always_ff @(posedge clk) begin
		if (en) q_s19 <= q_s18;
	end

	// Cap test: quotient exceeds the cap when charge*2^16 >= (cap+1)*r^2.
	logic [prd_pkg::CS_W-1:0] cap1;
	logic [prd_pkg::CM_W-1:0] cm_s4;
	logic                     capped_s5, capped_s19;

	assign cap1 = prd_pkg::CS_W'(cap_q) + prd_pkg::CS_W'(1);

	always_ff @(posedge clk) begin
		if (en) begin
			cm_s4     <= prd_pkg::CM_W'(cap1) * prd_pkg::CM_W'(r2_s3);
			capped_s5 <= prd_pkg::CM_W'({cs_q, 16'd0}) >= cm_s4;
		end
	end

	prd_dly #(.W(1), .D(14)) u_cap_dly (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.din    (capped_s5),
		.dout   (capped_s19)
	);

	// Distance r = floor(sqrt(r^2)), ready at stage 19.
	logic [prd_pkg::ROOT_W-1:0] root_s19, root_s20, root_s21;

	prd_sqrt #(.RW(prd_pkg::ROOT_W)) u_sqrt (
		.clk  (clk),
		.en   (en),
		.rad  ({1'b0, r2_s3}),
		.root (root_s19)
	);

	// Stage 20: clamp the coefficient; stage 21: coef times each distance.
	logic [prd_pkg::COEF_W-1:0] coef_s20;
	logic [DIST_W-1:0]          adx_s20, ady_s20;
	logic [prd_pkg::PROD_W-1:0] px_s21, py_s21;

	always_ff @(posedge clk) begin
		if (en) begin
			coef_s20 <= capped_s19 ? cap_q : q_s19;
			adx_s20  <= adx_s19;
			ady_s20  <= ady_s19;
			root_s20 <= root_s19;
			px_s21   <= coef_s20 * adx_s20;
			py_s21   <= coef_s20 * ady_s20;
			root_s21 <= root_s20;
		end
	end

	// Divide by r; |d| <= r keeps each quotient no greater than the coefficient.
	logic [prd_pkg::COEF_W-1:0] fx_s36, fy_s36;

	prd_div #(.NW(prd_pkg::PROD_W), .DW(prd_pkg::ROOT_W), .QW(prd_pkg::COEF_W)) u_fx_div (
		.clk (clk),
		.en  (en),
		.num (px_s21),
		.den (root_s21),
		.quo (fx_s36)
	);

	prd_div #(.NW(prd_pkg::PROD_W), .DW(prd_pkg::ROOT_W), .QW(prd_pkg::COEF_W)) u_fy_div (
		.clk (clk),
		.en  (en),
		.num (py_s21),
		.den (root_s21),
		.quo (fy_s36)
	);

	// Stage 37: apply force_scale, drop eight fraction bits.
	logic [prd_pkg::COEF_W+prd_pkg::FS_W-1:0] sgx, sgy;
	logic [G_W-1:0]                           gx_s37, gy_s37;

	assign sgx = fx_s36 * fs_q;
	assign sgy = fy_s36 * fs_q;

	always_ff @(posedge clk) begin
		if (en) begin
			gx_s37 <= sgx[prd_pkg::COEF_W+prd_pkg::FS_W-1:8];
			gy_s37 <= sgy[prd_pkg::COEF_W+prd_pkg::FS_W-1:8];
		end
	end

	// Stage 38: signed add, saturate, output register.
	function automatic logic [C-1:0] sat_add(input logic [C-1:0] v, input logic [G_W-1:0] g,
		input logic neg, input logic ok);
		logic [SUM_W-1:0] ve, ge, sum;
		logic [SUM_W-C:0] upper;
		ve    = {{(SUM_W - C){v[C-1]}}, v};
		ge    = ok ? {{(SUM_W - G_W){1'b0}}, g} : '0;
		sum   = neg ? ve - ge : ve + ge;
		upper = sum[SUM_W-1:C-1];
		if (!sum[SUM_W-1] && (|upper)) begin
			sat_add = {1'b0, {(C - 1){1'b1}}};
		end else if (sum[SUM_W-1] && !(&upper)) begin
			sat_add = {1'b1, {(C - 1){1'b0}}};
		end else begin
			sat_add = sum[C-1:0];
		end
	endfunction

	logic [C-1:0] nvx_q, nvy_q;
	logic         applied_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			nvx_q       <= '0;
			nvy_q       <= '0;
			applied_q   <= 1'b0;
		end else if (en) begin
			out_valid_q <= v_s37;
			nvx_q       <= sat_add(vx_s37, gx_s37, nx_s37, ok_s37);
			nvy_q       <= sat_add(vy_s37, gy_s37, ny_s37, ok_s37);
			applied_q   <= ok_s37 && ((gx_s37 != '0) || (gy_s37 != '0));
		end
	end

	assign m_tvalid   = out_valid_q;
	assign m_tdata    = OUT_W'({nvy_q, nvx_q});
	assign m_tuser[0] = applied_q;

	// A stall freezes the presented result.
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(out_valid_q) && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed during stall");

	// An input transfer enters stage 1.
	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> v_s1)
		else $error("accepted pair lost at stage 1");

	// A new result appears only from a valid item at stage 37.
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(v_s37))
		else $error("result shown without a valid item");

endmodule
